// ===== design/tlcd_pkg.sv =====
package tlcd_pkg;

	// Sizes of the configuration registers and the input reading
	localparam int RAW_W   = 12;
	localparam int ROW_W   = 2;
	localparam int COL_W   = 3;
	localparam int INT_W   = 8;
	localparam int BEAT_W  = 4;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Register reset values
	localparam logic [ROW_W-1:0] ROW_RESET = 2'd3;
	localparam logic [COL_W-1:0] COL_RESET = 3'd4;

	// Register indexes
	localparam logic REG_ROW = 1'b0;
	localparam logic REG_COL = 1'b1;

	// Characters
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	// Beat positions within one run of LCD writes
	localparam logic [BEAT_W-1:0] BEAT_ADDR  = 4'd0;
	localparam logic [BEAT_W-1:0] BEAT_SIGN  = 4'd1;
	localparam logic [BEAT_W-1:0] BEAT_HUNDS = 4'd2;
	localparam logic [BEAT_W-1:0] BEAT_TENS  = 4'd3;
	localparam logic [BEAT_W-1:0] BEAT_ONES  = 4'd4;
	localparam logic [BEAT_W-1:0] BEAT_DOT   = 4'd5;
	localparam logic [BEAT_W-1:0] BEAT_TENTH = 4'd6;
	localparam logic [BEAT_W-1:0] BEAT_HUNTH = 4'd7;
	localparam logic [BEAT_W-1:0] BEAT_UNIT  = 4'd8;

	// Decoded reading: sign, three integer digits, two fraction digits
	typedef struct packed {
		logic        neg;
		logic [11:0] int_bcd;
		logic [7:0]  frac_bcd;
	} text_t;

	// Set-address base of each text row
	function automatic logic [7:0] row_base(input logic [ROW_W-1:0] row);
		logic [7:0] base;
		case (row)
			2'd0: base = 8'h80;
			2'd1: base = 8'h90;
			2'd2: base = 8'h88;
			2'd3: base = 8'h98;
			default: base = 8'h80;
		endcase
		return base;
	endfunction

	// Sixteenths to hundredths, rounded half up, as two BCD digits
	function automatic logic [7:0] frac_to_bcd(input logic [3:0] f);
		logic [7:0] d;
		case (f)
			4'd0:  d = 8'h00;
			4'd1:  d = 8'h06;
			4'd2:  d = 8'h13;
			4'd3:  d = 8'h19;
			4'd4:  d = 8'h25;
			4'd5:  d = 8'h31;
			4'd6:  d = 8'h38;
			4'd7:  d = 8'h44;
			4'd8:  d = 8'h50;
			4'd9:  d = 8'h56;
			4'd10: d = 8'h63;
			4'd11: d = 8'h69;
			4'd12: d = 8'h75;
			4'd13: d = 8'h81;
			4'd14: d = 8'h88;
			4'd15: d = 8'h94;
			default: d = 8'h00;
		endcase
		return d;
	endfunction

	// Eight-bit binary to three BCD digits, shift and add three
	function automatic logic [11:0] bin_to_bcd(input logic [INT_W-1:0] bin);
		logic [11:0]      bcd;
		logic [INT_W-1:0] sh;
		bcd = '0;
		sh  = bin;
		for (int i = 0; i < INT_W; i++) begin
			if (bcd[3:0] >= 4'd5) bcd[3:0] = bcd[3:0] + 4'd3;
			if (bcd[7:4] >= 4'd5) bcd[7:4] = bcd[7:4] + 4'd3;
			if (bcd[11:8] >= 4'd5) bcd[11:8] = bcd[11:8] + 4'd3;
			bcd = {bcd[10:0], sh[INT_W-1]};
			sh  = {sh[INT_W-2:0], 1'b0};
		end
		return bcd;
	endfunction

endpackage

// ===== design/tlcd_front.sv =====
module tlcd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tlcd_pkg::RAW_W-1:0]  raw_temp,
	output logic                        push_valid,
	input  logic                        push_ready,
	output tlcd_pkg::text_t             push_text
);

	logic                        v_s1;
	logic [tlcd_pkg::RAW_W-1:0]  raw_s1;
	logic                        neg;
	logic [tlcd_pkg::RAW_W-1:0]  mag;

	// Take a new reading whenever the stage is empty or drains this cycle
	assign in_ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			raw_s1 <= raw_temp;
		end
	end

	// Magnitude; the most negative reading negates to itself, read unsigned
	assign neg = raw_s1[tlcd_pkg::RAW_W-1];
	assign mag = neg ? (~raw_s1 + tlcd_pkg::RAW_W'(1)) : raw_s1;

	// Whole degrees are mag/16, the fraction never carries into them
	assign push_valid         = v_s1;
	assign push_text.neg      = neg;
	assign push_text.int_bcd  = tlcd_pkg::bin_to_bcd(mag[tlcd_pkg::RAW_W-1:4]);
	assign push_text.frac_bcd = tlcd_pkg::frac_to_bcd(mag[3:0]);

endmodule

// ===== design/tlcd_queue.sv =====
module tlcd_queue #(
	parameter int Depth = tlcd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tlcd_pkg::text_t push_text,
	output logic            pop_valid,
	input  logic            pop,
	output tlcd_pkg::text_t pop_text
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	tlcd_pkg::text_t  mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CntW'(Depth);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_text   = mem_q[rd_ptr_q];

	// Advance pointers with wrap and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CntW'(1);
				2'b01:   cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_text;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue fill level beyond depth");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CntW'(Depth) && !do_pop) |=> cnt_q == CntW'(Depth))
		else $error("full queue lost an entry");

endmodule

// ===== design/tlcd_back.sv =====
module tlcd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tlcd_pkg::ROW_W-1:0]  display_row,
	input  logic [tlcd_pkg::COL_W-1:0]  display_col,
	input  logic                        pop_valid,
	output logic                        pop,
	input  tlcd_pkg::text_t             pop_text,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,
	output logic                        m_tuser,
	output logic                        m_tlast
);

	logic [tlcd_pkg::BEAT_W-1:0] beat_q;
	logic                        valid_q;
	logic [7:0]                  byte_q;
	logic                        data_q;
	logic                        last_q;
	logic                        load;
	logic [7:0]                  beat_byte;

	// Load the next beat when the output register is free or being taken
	assign load = pop_valid && (!valid_q || m_tready);
	assign pop  = load && (beat_q == tlcd_pkg::BEAT_UNIT);

	// Select the byte of the current beat
	always_comb begin
		case (beat_q)
			tlcd_pkg::BEAT_ADDR:
				beat_byte = tlcd_pkg::row_base(display_row) + {5'b0, display_col};
			tlcd_pkg::BEAT_SIGN:
				beat_byte = pop_text.neg ? tlcd_pkg::CHAR_MINUS : tlcd_pkg::CHAR_PLUS;
			tlcd_pkg::BEAT_HUNDS:
				beat_byte = tlcd_pkg::CHAR_ZERO | {4'b0, pop_text.int_bcd[11:8]};
			tlcd_pkg::BEAT_TENS:
				beat_byte = tlcd_pkg::CHAR_ZERO | {4'b0, pop_text.int_bcd[7:4]};
			tlcd_pkg::BEAT_ONES:
				beat_byte = tlcd_pkg::CHAR_ZERO | {4'b0, pop_text.int_bcd[3:0]};
			tlcd_pkg::BEAT_DOT:
				beat_byte = tlcd_pkg::CHAR_DOT;
			tlcd_pkg::BEAT_TENTH:
				beat_byte = tlcd_pkg::CHAR_ZERO | {4'b0, pop_text.frac_bcd[7:4]};
			tlcd_pkg::BEAT_HUNTH:
				beat_byte = tlcd_pkg::CHAR_ZERO | {4'b0, pop_text.frac_bcd[3:0]};
			tlcd_pkg::BEAT_UNIT:
				beat_byte = tlcd_pkg::CHAR_C;
			default:
				beat_byte = tlcd_pkg::CHAR_C;
		endcase
	end

	// Advance the beat counter and hold the output until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q  <= tlcd_pkg::BEAT_ADDR;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q <= pop ? tlcd_pkg::BEAT_ADDR : beat_q + tlcd_pkg::BEAT_W'(1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= beat_byte;
			data_q <= beat_q != tlcd_pkg::BEAT_ADDR;
			last_q <= beat_q == tlcd_pkg::BEAT_UNIT;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = data_q;
	assign m_tlast  = last_q;

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q <= tlcd_pkg::BEAT_UNIT)
		else $error("beat counter out of range");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> data_q)
		else $error("last beat marked as command");

	a_cmd_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !data_q) |-> byte_q[7])
		else $error("command beat without set-address bit");

	a_pop_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> beat_q == tlcd_pkg::BEAT_ADDR)
		else $error("counter did not restart after last beat");

endmodule

// ===== design/temperature_to_lcd_text_writer.sv =====
// Temperature to character-LCD text writer.
// Slave stream: one beat per raw sensor reading, s_tdata[11:0] two's
// complement in 1/16 degree C. Master stream: LCD bus writes, m_tdata the
// byte, m_tuser high for character data and low for a command, m_tlast on
// the final write. Each reading gives nine beats: a set-address command
// (row base plus column), then sign, three integer digits, '.', two
// fraction digits and 'C', hundredths rounded half up.
// The first beat of a reading passes the front stage register, the text
// queue and the back-end output register. The serializer emits one write
// per cycle while a reading is queued and the receiver is ready; the front
// stage and the two-entry text queue keep taking readings meanwhile.
// When the receiver stalls, the output beat holds and the queue fills;
// s_tready drops once the front stage and the queue are full.
// Reset clears all streams, empties the queue and sets row 3, column 4.
// APB registers: 0x0 display_row, 0x4 display_col; write while idle.
module temperature_to_lcd_text_writer #(
	parameter int QueueDepth = tlcd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Readings in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [11:0] raw_temp, [15:12] zero
	// LCD writes out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] bus_byte
	output logic        m_tuser,  // [0] is_data
	output logic        m_tlast
);

	logic [tlcd_pkg::ROW_W-1:0] row_q;
	logic [tlcd_pkg::COL_W-1:0] col_q;
	logic                       cfg_wr;
	logic                       push_valid;
	logic                       push_ready;
	tlcd_pkg::text_t            push_text;
	logic                       pop_valid;
	logic                       pop;
	tlcd_pkg::text_t            pop_text;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= tlcd_pkg::ROW_RESET;
			col_q <= tlcd_pkg::COL_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				tlcd_pkg::REG_ROW: row_q <= pwdata[tlcd_pkg::ROW_W-1:0];
				tlcd_pkg::REG_COL: col_q <= pwdata[tlcd_pkg::COL_W-1:0];
				default:           row_q <= row_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == tlcd_pkg::REG_COL) ? {29'b0, col_q} : {30'b0, row_q};

	tlcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.raw_temp   (s_tdata[tlcd_pkg::RAW_W-1:0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_text  (push_text)
	);

	tlcd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_text  (push_text),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_text   (pop_text)
	);

	tlcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.display_row (row_q),
		.display_col (col_q),
		.pop_valid   (pop_valid),
		.pop         (pop),
		.pop_text    (pop_text),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule
